FILE: hdl/drq_pkg.sv
package drq_pkg;

    localparam int CAPACITY = 16;
    localparam int TAG_BITS = 8;
    localparam int SLOT_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int DL_BITS = 64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_TAKE_FIRST = 2'd1;
    localparam logic [1:0] OP_TAKE_SECOND = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [63:0] deadline;
        logic [7:0] task_tag;
    } t_in_item;

    typedef struct packed {
        logic taken_valid;
        logic [7:0] taken_tag;
        logic [63:0] taken_deadline;
        logic error;
        logic [63:0] earliest_deadline;
        logic [63:0] next_deadline;
        logic [4:0] task_count;
        logic overloaded;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic scan_min;
        logic scan_sec;
    } t_dp_cmd;

    function automatic logic is_before(input logic [DL_BITS-1:0] x,
                                       input logic [DL_BITS-1:0] y);
        logic [DL_BITS-1:0] diff;
        diff = x - y;
        return diff[DL_BITS-1];
    endfunction

endpackage

FILE: hdl/drq_datapath.sv
module drq_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  drq_pkg::t_dp_cmd  i_cmd,
    input  drq_pkg::t_in_item i_item,
    output logic              o_scan_last,
    output drq_pkg::t_out_item o_result
);

    // task store in arrival order: entry 0 is oldest
    // wrap-around compare is not transitive, so minimum is scanned oldest first
    logic [drq_pkg::DL_BITS-1:0]   r_dl  [drq_pkg::CAPACITY];
    logic [drq_pkg::TAG_BITS-1:0]  r_tag [drq_pkg::CAPACITY];
    logic [drq_pkg::CNT_BITS-1:0]  r_count;
    drq_pkg::t_in_item             r_item;
    logic                          r_err;
    logic                          r_taken;
    logic [drq_pkg::TAG_BITS-1:0]  r_taken_tag;
    logic [drq_pkg::DL_BITS-1:0]   r_taken_dl;
    logic [drq_pkg::SLOT_BITS-1:0] r_min_idx;
    logic [drq_pkg::SLOT_BITS-1:0] r_sec_idx;
    logic [drq_pkg::SLOT_BITS-1:0] r_idx;
    logic [drq_pkg::SLOT_BITS-1:0] r_best;
    logic                          r_best_ok;
    drq_pkg::t_out_item            r_result;

    logic [drq_pkg::DL_BITS-1:0]   n_dl  [drq_pkg::CAPACITY];
    logic [drq_pkg::TAG_BITS-1:0]  n_tag [drq_pkg::CAPACITY];
    logic [drq_pkg::CNT_BITS-1:0]  n_count;
    logic [drq_pkg::SLOT_BITS-1:0] n_best;
    logic                          n_best_ok;
    drq_pkg::t_out_item            n_result;

    logic w_err;
    logic w_take;
    logic [drq_pkg::SLOT_BITS-1:0] w_pick;
    logic w_consider;
    logic w_last;

    always_comb begin
        w_err = 1'b0;
        w_take = 1'b0;
        w_pick = r_min_idx;
        case (r_item.opcode)
            drq_pkg::OP_INSERT: begin
                w_err = (r_count >= drq_pkg::CNT_BITS'(drq_pkg::CAPACITY));
            end
            drq_pkg::OP_TAKE_FIRST: begin
                w_err = (r_count < drq_pkg::CNT_BITS'(1));
                w_take = !w_err;
            end
            drq_pkg::OP_TAKE_SECOND: begin
                w_err = (r_count < drq_pkg::CNT_BITS'(2));
                w_take = !w_err;
                w_pick = r_sec_idx;
            end
            default: begin
                w_err = 1'b1;
            end
        endcase
    end

    // append on insert, close the gap on take
    always_comb begin
        n_count = r_count;
        for (int i = 0; i < drq_pkg::CAPACITY; i++) begin
            n_dl[i] = r_dl[i];
            n_tag[i] = r_tag[i];
        end
        if (r_item.opcode == drq_pkg::OP_INSERT && !w_err) begin
            n_count = r_count + drq_pkg::CNT_BITS'(1);
            for (int i = 0; i < drq_pkg::CAPACITY; i++) begin
                if (drq_pkg::CNT_BITS'(i) == r_count) begin
                    n_dl[i] = r_item.deadline;
                    n_tag[i] = r_item.task_tag[drq_pkg::TAG_BITS-1:0];
                end
            end
        end else if (w_take) begin
            n_count = r_count - drq_pkg::CNT_BITS'(1);
            for (int i = 0; i < drq_pkg::CAPACITY - 1; i++) begin
                if (drq_pkg::SLOT_BITS'(i) >= w_pick) begin
                    n_dl[i] = r_dl[i+1];
                    n_tag[i] = r_tag[i+1];
                end
            end
        end
    end

    // one entry per cycle, replaced only by a strictly earlier deadline
    always_comb begin
        w_consider = (drq_pkg::CNT_BITS'(r_idx) < r_count) &&
            !(i_cmd.scan_sec && (r_idx == r_min_idx));
        n_best = r_best;
        n_best_ok = r_best_ok;
        if (w_consider && (!r_best_ok || drq_pkg::is_before(r_dl[r_idx], r_dl[r_best]))) begin
            n_best = r_idx;
            n_best_ok = 1'b1;
        end
        w_last = ((drq_pkg::CNT_BITS'(r_idx) + drq_pkg::CNT_BITS'(1)) >= r_count);
    end

    always_comb begin
        n_result = '0;
        n_result.error = r_err;
        n_result.taken_valid = r_taken;
        n_result.taken_tag = 8'(r_taken_tag);
        n_result.taken_deadline = r_taken_dl;
        n_result.task_count = 5'(r_count);
        n_result.overloaded = (r_count > drq_pkg::CNT_BITS'(1));
        n_result.earliest_deadline = (r_count != '0) ? r_dl[r_min_idx] : '0;
        n_result.next_deadline = n_best_ok ? r_dl[n_best] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < drq_pkg::CAPACITY; i++) begin
                r_dl[i] <= n_dl[i];
                r_tag[i] <= n_tag[i];
            end
            r_err <= w_err;
            r_taken <= w_take;
            r_taken_tag <= w_take ? r_tag[w_pick] : '0;
            r_taken_dl <= w_take ? r_dl[w_pick] : '0;
        end
        if (i_cmd.scan_sec && w_last) begin
            r_result <= n_result;
        end
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx <= '0;
            r_best <= '0;
            r_best_ok <= 1'b0;
            r_min_idx <= '0;
            r_sec_idx <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
            r_idx <= '0;
            r_best_ok <= 1'b0;
        end else if (i_cmd.scan_min || i_cmd.scan_sec) begin
            if (w_last) begin
                r_idx <= '0;
                r_best_ok <= 1'b0;
                if (i_cmd.scan_min) begin
                    r_min_idx <= n_best;
                end else begin
                    r_sec_idx <= n_best;
                end
            end else begin
                r_idx <= r_idx + drq_pkg::SLOT_BITS'(1);
                r_best <= n_best;
                r_best_ok <= n_best_ok;
            end
        end
    end

    assign o_scan_last = w_last;
    assign o_result = r_result;

endmodule

FILE: hdl/drq_ctrl.sv
module drq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  logic             i_scan_last,
    output drq_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_EXEC     = 5'b00010,
        ST_SCAN_MIN = 5'b00100,
        ST_SCAN_SEC = 5'b01000,
        ST_OUT      = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = ST_SCAN_MIN;
            end
            ST_SCAN_MIN: begin
                o_cmd.scan_min = 1'b1;
                if (i_scan_last) begin
                    n_state = ST_SCAN_SEC;
                end
            end
            ST_SCAN_SEC: begin
                o_cmd.scan_sec = 1'b1;
                if (i_scan_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    o_in_stall = 1'b0;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state = ST_EXEC;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = (r_state == ST_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/deadline_run_queue.sv
// channel | direction | handshake                 | payload
// in      | input     | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
// out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
// after acceptance: one store update, then a scan for the earliest and a scan for the
//   second, one entry per cycle in arrival order; the result is registered at the end of the second scan
// a new transaction is taken as the result leaves, not while a result is pending
// synchronous active-low reset empties the queue
// a stalled result holds its payload; input is stalled meanwhile
module deadline_run_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  drq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output drq_pkg::t_out_item o_out_item
);

    drq_pkg::t_dp_cmd w_cmd;
    logic w_scan_last;

    drq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_scan_last(w_scan_last),
        .o_cmd      (w_cmd)
    );

    drq_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_item     (i_in_item),
        .o_scan_last(w_scan_last),
        .o_result   (o_out_item)
    );

endmodule

FILE: hdl/drq_checker.sv
module drq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input drq_pkg::t_out_item o_out_item
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_overload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.overloaded == (o_out_item.task_count > 5'd1))
        else $error("overloaded flag mismatch");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.task_count <= 5'd16)
        else $error("count too large");

    a_err_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.error && o_out_item.taken_valid))
        else $error("error with take");

    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall && !o_out_valid)
        else $error("accept too soon");

endmodule

bind deadline_run_queue drq_checker u_drq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);

FILE: sim/deadline_run_queue_tb.sv
`timescale 1ns / 1ps

module deadline_run_queue_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] OP_ILLEGAL = 2'd3;

    typedef struct {
        logic [1:0] opcode;
        logic [63:0] deadline;
        logic [7:0] tag;
        bit typed;
        drq_pkg::t_out_item expected;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    drq_pkg::t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    drq_pkg::t_out_item o_out_item;

    deadline_run_queue uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // run queue shadow
    logic [63:0] q_deadline [drq_pkg::CAPACITY];
    logic [7:0] q_tag [drq_pkg::CAPACITY];
    bit q_used [drq_pkg::CAPACITY];
    int q_age [drq_pkg::CAPACITY];
    int q_count = 0;

    drq_pkg::t_out_item result_queue [$];
    drq_pkg::t_out_item typed_queue [$];
    bit typed_flag_queue [$];
    int mismatches = 0;
    int idle_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit timed_out = 0;

    function automatic bit earlier(logic [63:0] x, logic [63:0] y);
        logic [63:0] d;
        d = x - y;
        return d[63];
    endfunction

    function automatic int pick_earliest(int skip);
        int best;
        best = -1;
        for (int a = 0; a < q_count; a++)
            for (int s = 0; s < drq_pkg::CAPACITY; s++)
                if (q_used[s] && s != skip && q_age[s] == a)
                    if (best < 0 || earlier(q_deadline[s], q_deadline[best])) best = s;
        return best;
    endfunction

    function automatic drq_pkg::t_out_item queue_step(logic [1:0] op, logic [63:0] dl,
                                                      logic [7:0] tag);
        drq_pkg::t_out_item r;
        int pick, m, n;
        r = '0;
        pick = -1;
        case (op)
            drq_pkg::OP_INSERT: begin
                if (q_count >= drq_pkg::CAPACITY) begin
                    r.error = 1'b1;
                end else begin
                    for (int s = 0; s < drq_pkg::CAPACITY; s++)
                        if (!q_used[s]) begin
                            q_deadline[s] = dl;
                            q_tag[s] = tag;
                            q_age[s] = q_count;
                            q_used[s] = 1;
                            q_count++;
                            break;
                        end
                end
            end
            drq_pkg::OP_TAKE_FIRST: begin
                if (q_count < 1) r.error = 1'b1;
                else pick = pick_earliest(-1);
            end
            drq_pkg::OP_TAKE_SECOND: begin
                if (q_count < 2) r.error = 1'b1;
                else pick = pick_earliest(pick_earliest(-1));
            end
            default: r.error = 1'b1;
        endcase
        if (pick >= 0) begin
            r.taken_valid = 1'b1;
            r.taken_tag = q_tag[pick];
            r.taken_deadline = q_deadline[pick];
            q_used[pick] = 0;
            for (int s = 0; s < drq_pkg::CAPACITY; s++)
                if (q_used[s] && q_age[s] > q_age[pick]) q_age[s]--;
            q_count--;
        end
        m = pick_earliest(-1);
        n = (m >= 0) ? pick_earliest(m) : -1;
        r.earliest_deadline = (m >= 0) ? q_deadline[m] : '0;
        r.next_deadline = (n >= 0) ? q_deadline[n] : '0;
        r.task_count = q_count[4:0];
        r.overloaded = q_count > 1;
        return r;
    endfunction

    // valid stays high after acceptance until the next call or drain takes it over
    task automatic send(logic [1:0] op, logic [63:0] dl, logic [7:0] tag,
                        bit typed, drq_pkg::t_out_item typed_val);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= '{opcode: op, deadline: dl, task_tag: tag};
        result_queue.push_back(queue_step(op, dl, tag));
        typed_flag_queue.push_back(typed);
        typed_queue.push_back(typed_val);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (result_queue.size() > 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // result checking
    always @(posedge i_clk) begin
        drq_pkg::t_out_item exp_item;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_item);
            end else begin
                exp_item = result_queue.pop_front();
                if (typed_flag_queue.pop_front() && typed_queue[0] !== exp_item) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row disagrees: table %p predicted %p",
                                 typed_queue[0], exp_item);
                end
                void'(typed_queue.pop_front());
                if (o_out_item !== exp_item) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_item, o_out_item);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[deadline_run_queue] ERROR");
            $finish;
        end
    end

    function automatic drq_pkg::t_out_item mk(bit tv, logic [7:0] tt, logic [63:0] td,
                                              bit er, logic [63:0] e, logic [63:0] n,
                                              int c);
        drq_pkg::t_out_item r;
        r = '{taken_valid: tv, taken_tag: tt, taken_deadline: td, error: er,
              earliest_deadline: e, next_deadline: n, task_count: c[4:0],
              overloaded: c > 1};
        return r;
    endfunction

    function automatic logic [63:0] rand_dl(int mode);
        logic [63:0] d;
        d = {$urandom, $urandom};
        case (mode)
            0: d = 64'd1000 + $urandom_range(7);
            1: d = 64'hFFFF_FFFF_FFFF_FFF8 + $urandom_range(15);
            2: d = 64'h8000_0000_0000_0000 + $urandom_range(7) - 3;
            default: ;
        endcase
        return d;
    endfunction

    t_row table_rows [$];
    int phase_idle [4] = '{0, 65, 0, 38};
    int phase_stall [4] = '{0, 0, 65, 38};

    initial begin
        logic [1:0] op;
        int r;
        for (int s = 0; s < drq_pkg::CAPACITY; s++) q_used[s] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        table_rows.push_back('{drq_pkg::OP_TAKE_FIRST, 0, 0, 1, mk(0, 0, 0, 1, 0, 0, 0)});
        table_rows.push_back('{drq_pkg::OP_TAKE_SECOND, 0, 0, 1, mk(0, 0, 0, 1, 0, 0, 0)});
        table_rows.push_back('{OP_ILLEGAL, 5, 1, 1, mk(0, 0, 0, 1, 0, 0, 0)});
        table_rows.push_back('{drq_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1,
                               mk(0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1)});
        table_rows.push_back('{drq_pkg::OP_TAKE_SECOND, 0, 0, 1,
                               mk(0, 0, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1)});
        table_rows.push_back('{drq_pkg::OP_INSERT, 64'd1, 8'h00, 0, '0});
        table_rows.push_back('{drq_pkg::OP_INSERT, 64'd0, 8'h5A, 0, '0});
        table_rows.push_back('{drq_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 8'hA5, 0, '0});
        table_rows.push_back('{drq_pkg::OP_INSERT, 64'd1, 8'h11, 0, '0});
        table_rows.push_back('{drq_pkg::OP_TAKE_SECOND, 0, 0, 0, '0});
        table_rows.push_back('{drq_pkg::OP_TAKE_FIRST, 0, 0, 0, '0});
        table_rows.push_back('{OP_ILLEGAL, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 0, '0});
        for (int i = 0; i < 14; i++)
            table_rows.push_back('{drq_pkg::OP_INSERT, 64'd50 - i, i[7:0], 0, '0});
        foreach (table_rows[i])
            send(table_rows[i].opcode, table_rows[i].deadline, table_rows[i].tag,
                 table_rows[i].typed, table_rows[i].expected);
        // store is full now
        send(drq_pkg::OP_INSERT, 64'd7, 8'h77, 0, '0);
        drain();

        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = phase_idle[p];
            receiver_stall_pct = phase_stall[p];
            for (int i = 0; i < 470; i++) begin
                r = $urandom_range(99);
                if (r < 3) op = OP_ILLEGAL;
                else if (q_count < 3)
                    op = (r < 80) ? drq_pkg::OP_INSERT : 2'($urandom_range(2, 1));
                else if (q_count > 13)
                    op = (r < 30) ? drq_pkg::OP_INSERT : 2'($urandom_range(2, 1));
                else
                    op = (r < 50) ? drq_pkg::OP_INSERT :
                         ((r < 75) ? drq_pkg::OP_TAKE_FIRST : drq_pkg::OP_TAKE_SECOND);
                send(op, rand_dl($urandom_range(5)), 8'($urandom), 0, '0);
                if (i == 200) drain();
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && result_queue.size() == 0)
            $display("[deadline_run_queue] OK");
        else
            $display("[deadline_run_queue] ERROR");
        $finish;
    end
endmodule
